// ----- rtl/hse_pkg.sv -----
// Shared types, constants and helpers for the Heisenberg site energy block.
// Used by hse_ctrl, hse_dpath and the heisenberg_site_energy top level.
package hse_pkg;

   // Default parameter values
   localparam int SPIN_BITS_DEF  = 16;
   localparam int ACCUM_BITS_DEF = 64;

   // Fixed field widths
   localparam int Q15_BITS      = 16;
   localparam int COEF_BITS     = 16;
   localparam int MODE_BITS     = 5;
   localparam int OUT_BITS      = 48;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // Datapath widths: multiplier operands, product, partial sum, held product, term
   localparam int OPA_BITS  = 32;
   localparam int OPB_BITS  = 34;
   localparam int PROD_BITS = 64;
   localparam int SUM_BITS  = 34;
   localparam int HOLD_BITS = 32;
   localparam int TERM_BITS = 42;

   // Rounding shifts of each term (factor two folded into the axis and rhombic shifts)
   localparam int EXCH_SHIFT   = 14;
   localparam int AXIS_SHIFT   = 21;
   localparam int RHOMB_SHIFT  = 13;
   localparam int ZEEMAN_SHIFT = 3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_X  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_Y  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_Z  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_X = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_Y = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_Z = 3'd6;

   // Mode register bits
   localparam int MODE_AXIS_X = 0;
   localparam int MODE_AXIS_Y = 1;
   localparam int MODE_AXIS_Z = 2;
   localparam int MODE_FIELD  = 3;
   localparam int MODE_RHOMB  = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_P5,
      ST_RND,
      ST_ACC,
      ST_DONE
   } state_type;

   // Energy terms in the order they enter the accumulator
   typedef enum logic [2:0] {
      JOB_EXCH,
      JOB_AXIS_X,
      JOB_AXIS_Y,
      JOB_AXIS_Z,
      JOB_RHOMB_E,
      JOB_ZEEMAN
   } job_type;

   localparam int JOB_FIRST_SITE = 1;
   localparam int JOB_LAST_SITE  = 5;

   typedef enum logic [3:0] {
      A_OWN_X,
      A_OWN_Y,
      A_OWN_Z,
      A_EXCH,
      A_COEF_X,
      A_COEF_Y,
      A_COEF_Z,
      A_FIELD_X,
      A_FIELD_Y,
      A_FIELD_Z,
      A_HOLD
   } opa_sel_type;

   typedef enum logic [3:0] {
      B_NBR_X,
      B_NBR_Y,
      B_NBR_Z,
      B_OWN_X,
      B_OWN_Y,
      B_OWN_Z,
      B_RATIO_X,
      B_RATIO_Y,
      B_RATIO_Z,
      B_SUM
   } opb_sel_type;

   typedef enum logic [2:0] {
      SUM_KEEP,
      SUM_LOAD,
      SUM_LOAD_NEG,
      SUM_ADD,
      SUM_SUB
   } sum_op_type;

   typedef enum logic [2:0] {
      RND_NONE,
      RND_EXCH,
      RND_AXIS,
      RND_RHOMB,
      RND_ZEEMAN
   } rnd_op_type;

   typedef struct packed {
      logic        load_in;
      opa_sel_type a_sel;
      opb_sel_type b_sel;
      logic        mul_en;
      sum_op_type  sum_op;
      logic        hold_en;
      rnd_op_type  rnd_op;
      logic        acc_en;
      logic        emit;
   } dp_cmd_type;

   typedef struct packed {
      logic                 out_busy;
      logic [MODE_BITS-1:0] mode;
   } dp_stat_type;

   // Whether a single-site term is selected by the mode register
   function automatic logic job_enabled(input job_type job, input logic [MODE_BITS-1:0] mode);
      logic en;
      en = 1'b0;
      case (job)
         JOB_AXIS_X:  en = !mode[MODE_RHOMB] && mode[MODE_AXIS_X];
         JOB_AXIS_Y:  en = !mode[MODE_RHOMB] && mode[MODE_AXIS_Y];
         JOB_AXIS_Z:  en = mode[MODE_RHOMB] || mode[MODE_AXIS_Z];
         JOB_RHOMB_E: en = mode[MODE_RHOMB];
         JOB_ZEEMAN:  en = mode[MODE_FIELD];
         default:     en = 1'b0;
      endcase
      return en;
   endfunction

endpackage

// ----- rtl/hse_dpath.sv -----
// Datapath of the Heisenberg site energy block: input item registers, config
// registers, shared multiplier, rounding, saturating accumulator, result register.
// Depends on hse_pkg; driven by hse_ctrl through dp_cmd_type.
module hse_dpath
   import hse_pkg::*;
#(
   parameter int SPIN_BITS  = SPIN_BITS_DEF,
   parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dp_cmd_type                      cmd,
   output dp_stat_type                     stat,
   input  logic signed [SPIN_BITS-1:0]     req_nbr_sx,
   input  logic signed [SPIN_BITS-1:0]     req_nbr_sy,
   input  logic signed [SPIN_BITS-1:0]     req_nbr_sz,
   input  logic signed [COEF_BITS-1:0]     req_exch_coef,
   input  logic signed [SPIN_BITS-1:0]     req_own_sx,
   input  logic signed [SPIN_BITS-1:0]     req_own_sy,
   input  logic signed [SPIN_BITS-1:0]     req_own_sz,
   input  logic signed [COEF_BITS-1:0]     req_ratio_x,
   input  logic signed [COEF_BITS-1:0]     req_ratio_y,
   input  logic signed [COEF_BITS-1:0]     req_ratio_z,
   input  logic                            csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [OUT_BITS-1:0]      rsp_site_energy,
   output logic                            rsp_energy_overflow
);

   localparam int SHL      = (SPIN_BITS < Q15_BITS) ? Q15_BITS - SPIN_BITS : 0;
   localparam int SHR      = (SPIN_BITS > Q15_BITS) ? SPIN_BITS - Q15_BITS : 0;
   localparam int WIDE     = SPIN_BITS + SHL;
   localparam int ACC_SUMW = ((ACCUM_BITS > TERM_BITS) ? ACCUM_BITS : TERM_BITS) + 1;
   localparam int EXT_W    = (ACCUM_BITS > OUT_BITS) ? ACCUM_BITS : OUT_BITS;

   localparam logic signed [PROD_BITS-1:0] EXCH_HALF  = PROD_BITS'(64'sd1 <<< (EXCH_SHIFT - 1));
   localparam logic signed [PROD_BITS-1:0] AXIS_HALF  = PROD_BITS'(64'sd1 <<< (AXIS_SHIFT - 1));
   localparam logic signed [PROD_BITS-1:0] RHOMB_HALF = PROD_BITS'(64'sd1 <<< (RHOMB_SHIFT - 1));

   localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS - 1){1'b1}}};
   localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS - 1){1'b0}}};
   localparam logic signed [OUT_BITS-1:0]   OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0]   OUT_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

   // Bring a spin component to Q1.15
   function automatic logic signed [Q15_BITS-1:0] to_q15(input logic signed [SPIN_BITS-1:0] raw);
      logic signed [WIDE-1:0] w;
      w = WIDE'(raw) <<< SHL;
      return Q15_BITS'(w >>> SHR);
   endfunction

   // Item registers
   logic signed [Q15_BITS-1:0]  nbr_x_ff, nbr_y_ff, nbr_z_ff;
   logic signed [Q15_BITS-1:0]  own_x_ff, own_y_ff, own_z_ff;
   logic signed [COEF_BITS-1:0] exch_ff, ratio_x_ff, ratio_y_ff, ratio_z_ff;

   // Configuration registers
   logic [MODE_BITS-1:0]        mode_ff;
   logic signed [COEF_BITS-1:0] coef_x_ff, coef_y_ff, coef_z_ff;
   logic signed [COEF_BITS-1:0] field_x_ff, field_y_ff, field_z_ff;

   // Arithmetic
   logic signed [OPA_BITS-1:0]            opa;
   logic signed [OPB_BITS-1:0]            opb;
   logic signed [OPA_BITS+OPB_BITS-1:0]   prod_full;
   logic signed [PROD_BITS-1:0]           prod_ff, prod_in;
   logic signed [SUM_BITS-1:0]            sum_ff, sum_in;
   logic signed [HOLD_BITS-1:0]           hold_ff;
   logic signed [PROD_BITS-1:0]           rnd_val;
   logic signed [TERM_BITS-1:0]           term_ff, term_in;
   logic signed [ACC_SUMW-1:0]            acc_sum;
   logic [ACC_SUMW-ACCUM_BITS:0]          acc_top;
   logic                                  acc_fits;
   logic signed [ACCUM_BITS-1:0]          acc_ff, acc_in;
   logic                                  ovf_ff, ovf_in;

   // Result
   logic signed [EXT_W-1:0]               out_ext;
   logic [EXT_W-OUT_BITS:0]               out_top;
   logic                                  out_fits;
   logic signed [OUT_BITS-1:0]            energy_in;
   logic                                  rsp_valid_ff;
   logic signed [OUT_BITS-1:0]            energy_ff;
   logic                                  energy_ovf_ff;

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         nbr_x_ff   <= to_q15(req_nbr_sx);
         nbr_y_ff   <= to_q15(req_nbr_sy);
         nbr_z_ff   <= to_q15(req_nbr_sz);
         own_x_ff   <= to_q15(req_own_sx);
         own_y_ff   <= to_q15(req_own_sy);
         own_z_ff   <= to_q15(req_own_sz);
         exch_ff    <= req_exch_coef;
         ratio_x_ff <= req_ratio_x;
         ratio_y_ff <= req_ratio_y;
         ratio_z_ff <= req_ratio_z;
      end
   end

   // Write configuration; drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         coef_x_ff  <= '0;
         coef_y_ff  <= '0;
         coef_z_ff  <= '0;
         field_x_ff <= '0;
         field_y_ff <= '0;
         field_z_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:    mode_ff    <= csr_wdata[MODE_BITS-1:0];
            CSR_COEF_X:  coef_x_ff  <= csr_wdata;
            CSR_COEF_Y:  coef_y_ff  <= csr_wdata;
            CSR_COEF_Z:  coef_z_ff  <= csr_wdata;
            CSR_FIELD_X: field_x_ff <= csr_wdata;
            CSR_FIELD_Y: field_y_ff <= csr_wdata;
            CSR_FIELD_Z: field_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Select multiplier operands
   always_comb begin
      case (cmd.a_sel)
         A_OWN_X:   opa = OPA_BITS'(own_x_ff);
         A_OWN_Y:   opa = OPA_BITS'(own_y_ff);
         A_OWN_Z:   opa = OPA_BITS'(own_z_ff);
         A_EXCH:    opa = OPA_BITS'(exch_ff);
         A_COEF_X:  opa = OPA_BITS'(coef_x_ff);
         A_COEF_Y:  opa = OPA_BITS'(coef_y_ff);
         A_COEF_Z:  opa = OPA_BITS'(coef_z_ff);
         A_FIELD_X: opa = OPA_BITS'(field_x_ff);
         A_FIELD_Y: opa = OPA_BITS'(field_y_ff);
         A_FIELD_Z: opa = OPA_BITS'(field_z_ff);
         A_HOLD:    opa = OPA_BITS'(hold_ff);
         default:   opa = '0;
      endcase
      case (cmd.b_sel)
         B_NBR_X:   opb = OPB_BITS'(nbr_x_ff);
         B_NBR_Y:   opb = OPB_BITS'(nbr_y_ff);
         B_NBR_Z:   opb = OPB_BITS'(nbr_z_ff);
         B_OWN_X:   opb = OPB_BITS'(own_x_ff);
         B_OWN_Y:   opb = OPB_BITS'(own_y_ff);
         B_OWN_Z:   opb = OPB_BITS'(own_z_ff);
         B_RATIO_X: opb = OPB_BITS'(ratio_x_ff);
         B_RATIO_Y: opb = OPB_BITS'(ratio_y_ff);
         B_RATIO_Z: opb = OPB_BITS'(ratio_z_ff);
         B_SUM:     opb = OPB_BITS'(sum_ff);
         default:   opb = '0;
      endcase
   end

   // Shared multiplier; every product used here fits in PROD_BITS
   assign prod_full = opa * opb;
   assign prod_in   = prod_full[PROD_BITS-1:0];

   // Partial sum of products
   always_comb begin
      case (cmd.sum_op)
         SUM_LOAD:     sum_in = SUM_BITS'(prod_ff);
         SUM_LOAD_NEG: sum_in = -SUM_BITS'(prod_ff);
         SUM_ADD:      sum_in = sum_ff + SUM_BITS'(prod_ff);
         SUM_SUB:      sum_in = sum_ff - SUM_BITS'(prod_ff);
         default:      sum_in = sum_ff;
      endcase
   end

   // Round a product half up to 2^-24 units, or scale the field sum
   always_comb begin
      rnd_val = '0;
      term_in = term_ff;
      case (cmd.rnd_op)
         RND_EXCH: begin
            rnd_val = (prod_ff + EXCH_HALF) >>> EXCH_SHIFT;
            term_in = TERM_BITS'(rnd_val);
         end
         RND_AXIS: begin
            rnd_val = (prod_ff + AXIS_HALF) >>> AXIS_SHIFT;
            term_in = TERM_BITS'(rnd_val);
         end
         RND_RHOMB: begin
            rnd_val = (prod_ff + RHOMB_HALF) >>> RHOMB_SHIFT;
            term_in = TERM_BITS'(rnd_val);
         end
         RND_ZEEMAN: term_in = TERM_BITS'(sum_ff) <<< ZEEMAN_SHIFT;
         default: ;
      endcase
   end

   // Saturating accumulate
   assign acc_sum  = ACC_SUMW'(acc_ff) + ACC_SUMW'(term_ff);
   assign acc_top  = acc_sum[ACC_SUMW-1:ACCUM_BITS-1];
   assign acc_fits = (&acc_top) | ~(|acc_top);

   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (cmd.emit) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.acc_en) begin
         if (acc_fits) begin
            acc_in = acc_sum[ACCUM_BITS-1:0];
         end else begin
            acc_in = acc_sum[ACC_SUMW-1] ? ACC_MIN : ACC_MAX;
            ovf_in = 1'b1;
         end
      end
   end

   // Clamp the total to the result width
   assign out_ext  = EXT_W'(acc_ff);
   assign out_top  = out_ext[EXT_W-1:OUT_BITS-1];
   assign out_fits = (&out_top) | ~(|out_top);

   always_comb begin
      if (out_fits) begin
         energy_in = out_ext[OUT_BITS-1:0];
      end else begin
         energy_in = out_ext[EXT_W-1] ? OUT_MIN : OUT_MAX;
      end
   end

   // Arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.hold_en) begin
         hold_ff <= HOLD_BITS'(prod_ff);
      end
      sum_ff  <= sum_in;
      term_ff <= term_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   // Result register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         energy_ff     <= energy_in;
         energy_ovf_ff <= ovf_ff | ~out_fits;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_site_energy     = energy_ff;
   assign rsp_energy_overflow = energy_ovf_ff;

   assign stat.out_busy = rsp_valid_ff & rsp_stall;
   assign stat.mode     = mode_ff;

`ifndef SYNTHESIS
   a_emit_clears_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (acc_ff == '0) && !ovf_ff && rsp_valid_ff)
      else $error("accumulator not cleared after result load");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result valid rose without a result load");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         rsp_valid_ff && $stable(energy_ff) && $stable(energy_ovf_ff))
      else $error("stalled result changed");
`endif

endmodule

// ----- rtl/hse_ctrl.sv -----
// Controller of the Heisenberg site energy block: sequences the shared
// multiplier through the exchange term and the selected single-site terms.
// Depends on hse_pkg; commands hse_dpath through dp_cmd_type.
module hse_ctrl
   import hse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_nbr_valid,
   input  logic        req_last_item,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic      last_ff, last_in;
   logic      accept;
   job_type   job_cur;
   job_type   job_next;
   logic      job_found;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Find the next enabled single-site term after the current one
   always_comb begin
      job_cur   = (state_ff == ST_IDLE) ? JOB_EXCH : job_ff;
      job_next  = JOB_EXCH;
      job_found = 1'b0;
      for (int i = JOB_LAST_SITE; i >= JOB_FIRST_SITE; i--) begin
         if ((3'(i) > job_cur) && job_enabled(job_type'(3'(i)), stat.mode)) begin
            job_next  = job_type'(3'(i));
            job_found = 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last_item;
               if (req_nbr_valid) begin
                  job_in   = JOB_EXCH;
                  state_in = ST_P1;
               end else if (req_last_item) begin
                  if (job_found) begin
                     job_in   = job_next;
                     state_in = ST_P1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_P1:  state_in = ST_P2;
         ST_P2:  state_in = ST_P3;
         ST_P3:  state_in = ST_P4;
         ST_P4:  state_in = ST_P5;
         ST_P5:  state_in = ST_RND;
         ST_RND: state_in = ST_ACC;
         ST_ACC: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (job_found) begin
               job_in   = job_next;
               state_in = ST_P1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands per state and term
   always_comb begin
      opa_sel_type ax_coef;
      opa_sel_type ax_own_a;
      opb_sel_type ax_ratio;
      opb_sel_type ax_own_b;

      case (job_ff)
         JOB_AXIS_Y: begin
            ax_coef  = A_COEF_Y;
            ax_own_a = A_OWN_Y;
            ax_ratio = B_RATIO_Y;
            ax_own_b = B_OWN_Y;
         end
         JOB_AXIS_Z: begin
            ax_coef  = A_COEF_Z;
            ax_own_a = A_OWN_Z;
            ax_ratio = B_RATIO_Z;
            ax_own_b = B_OWN_Z;
         end
         default: begin
            ax_coef  = A_COEF_X;
            ax_own_a = A_OWN_X;
            ax_ratio = B_RATIO_X;
            ax_own_b = B_OWN_X;
         end
      endcase

      cmd.load_in = 1'b0;
      cmd.a_sel   = A_OWN_X;
      cmd.b_sel   = B_NBR_X;
      cmd.mul_en  = 1'b0;
      cmd.sum_op  = SUM_KEEP;
      cmd.hold_en = 1'b0;
      cmd.rnd_op  = RND_NONE;
      cmd.acc_en  = 1'b0;
      cmd.emit    = 1'b0;

      unique case (state_ff)
         ST_IDLE: cmd.load_in = accept;
         ST_P1: begin
            cmd.mul_en = 1'b1;
            case (job_ff)
               JOB_EXCH: begin
                  cmd.a_sel = A_OWN_X;
                  cmd.b_sel = B_NBR_X;
               end
               JOB_RHOMB_E: begin
                  cmd.a_sel = A_OWN_X;
                  cmd.b_sel = B_OWN_X;
               end
               JOB_ZEEMAN: begin
                  cmd.a_sel = A_FIELD_X;
                  cmd.b_sel = B_OWN_X;
               end
               default: begin
                  cmd.a_sel = ax_coef;
                  cmd.b_sel = ax_ratio;
               end
            endcase
         end
         ST_P2: begin
            cmd.mul_en = 1'b1;
            case (job_ff)
               JOB_EXCH: begin
                  cmd.a_sel  = A_OWN_Y;
                  cmd.b_sel  = B_NBR_Y;
                  cmd.sum_op = SUM_LOAD;
               end
               JOB_RHOMB_E: begin
                  cmd.a_sel  = A_OWN_Y;
                  cmd.b_sel  = B_OWN_Y;
                  cmd.sum_op = SUM_LOAD;
               end
               JOB_ZEEMAN: begin
                  cmd.a_sel  = A_FIELD_Y;
                  cmd.b_sel  = B_OWN_Y;
                  cmd.sum_op = SUM_LOAD_NEG;
               end
               default: begin
                  cmd.a_sel   = ax_own_a;
                  cmd.b_sel   = ax_own_b;
                  cmd.hold_en = 1'b1;
               end
            endcase
         end
         ST_P3: begin
            case (job_ff)
               JOB_EXCH: begin
                  cmd.mul_en = 1'b1;
                  cmd.a_sel  = A_OWN_Z;
                  cmd.b_sel  = B_NBR_Z;
                  cmd.sum_op = SUM_ADD;
               end
               JOB_RHOMB_E: cmd.sum_op = SUM_SUB;
               JOB_ZEEMAN: begin
                  cmd.mul_en = 1'b1;
                  cmd.a_sel  = A_FIELD_Z;
                  cmd.b_sel  = B_OWN_Z;
                  cmd.sum_op = SUM_SUB;
               end
               default: cmd.sum_op = SUM_LOAD;
            endcase
         end
         ST_P4: begin
            case (job_ff)
               JOB_EXCH:   cmd.sum_op = SUM_ADD;
               JOB_ZEEMAN: cmd.sum_op = SUM_SUB;
               default: ;
            endcase
         end
         ST_P5: begin
            cmd.b_sel = B_SUM;
            case (job_ff)
               JOB_EXCH: begin
                  cmd.mul_en = 1'b1;
                  cmd.a_sel  = A_EXCH;
               end
               JOB_RHOMB_E: begin
                  cmd.mul_en = 1'b1;
                  cmd.a_sel  = A_COEF_X;
               end
               JOB_ZEEMAN: ;
               default: begin
                  cmd.mul_en = 1'b1;
                  cmd.a_sel  = A_HOLD;
               end
            endcase
         end
         ST_RND: begin
            case (job_ff)
               JOB_EXCH:    cmd.rnd_op = RND_EXCH;
               JOB_RHOMB_E: cmd.rnd_op = RND_RHOMB;
               JOB_ZEEMAN:  cmd.rnd_op = RND_ZEEMAN;
               default:     cmd.rnd_op = RND_AXIS;
            endcase
         end
         ST_ACC:  cmd.acc_en = 1'b1;
         ST_DONE: cmd.emit   = !stat.out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JOB_EXCH;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         last_ff  <= last_in;
      end
   end

`ifndef SYNTHESIS
   a_nbr_starts_exch: assert property (@(posedge clock) disable iff (reset)
      (accept && req_nbr_valid) |=> (state_ff == ST_P1) && (job_ff == JOB_EXCH))
      else $error("neighbor item did not start the exchange term");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stat.out_busy)
      else $error("result loaded while the result register is held");

   a_done_needs_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> last_ff)
      else $error("result stage reached without a final item");
`endif

endmodule

// ----- rtl/heisenberg_site_energy.sv -----
// An item that carries a neighbor occupies the block through accept, five multiplier
// steps, rounding and accumulate; an item without one that is not final is only accepted.
// A final item then runs these steps for each enabled single-site term on the single
// shared multiplier and loads the result, which is valid in the cycle after the load.
// Items are taken one at a time; a new item is taken while a result waits to be taken.
// Reset (synchronous, active high) clears control, accumulator and configuration to zero.
module heisenberg_site_energy
   import hse_pkg::*;
#(
   parameter int SPIN_BITS  = SPIN_BITS_DEF,
   parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SPIN_BITS-1:0]     req_nbr_sx,
   input  logic signed [SPIN_BITS-1:0]     req_nbr_sy,
   input  logic signed [SPIN_BITS-1:0]     req_nbr_sz,
   input  logic signed [COEF_BITS-1:0]     req_exch_coef,
   input  logic                            req_nbr_valid,
   input  logic signed [SPIN_BITS-1:0]     req_own_sx,
   input  logic signed [SPIN_BITS-1:0]     req_own_sy,
   input  logic signed [SPIN_BITS-1:0]     req_own_sz,
   input  logic signed [COEF_BITS-1:0]     req_ratio_x,
   input  logic signed [COEF_BITS-1:0]     req_ratio_y,
   input  logic signed [COEF_BITS-1:0]     req_ratio_z,
   input  logic                            req_last_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [OUT_BITS-1:0]      rsp_site_energy,
   output logic                            rsp_energy_overflow,
   input  logic                            csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequence the terms
   hse_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_nbr_valid (req_nbr_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Compute and hold the energy
   hse_dpath #(
      .SPIN_BITS  (SPIN_BITS),
      .ACCUM_BITS (ACCUM_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_nbr_sx          (req_nbr_sx),
      .req_nbr_sy          (req_nbr_sy),
      .req_nbr_sz          (req_nbr_sz),
      .req_exch_coef       (req_exch_coef),
      .req_own_sx          (req_own_sx),
      .req_own_sy          (req_own_sy),
      .req_own_sz          (req_own_sz),
      .req_ratio_x         (req_ratio_x),
      .req_ratio_y         (req_ratio_y),
      .req_ratio_z         (req_ratio_z),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_site_energy     (rsp_site_energy),
      .rsp_energy_overflow (rsp_energy_overflow)
   );

endmodule

// ----- tb/heisenberg_site_energy_tb.sv -----
// Testbench for heisenberg_site_energy: directed and random neighbor items with
// random idling on both sides, a self-contained site energy predictor and a result checker.
// Depends on hse_pkg and the heisenberg_site_energy RTL.
module heisenberg_site_energy_tb;
   import hse_pkg::*;

   localparam int EXCH_RND   = 14;
   localparam int AXIS_RND   = 22;
   localparam int SETTLE     = 50;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 400;
   localparam int LONG_COUNT = 60;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam logic [15:0] W_MIN = 16'h8000;
   localparam logic [15:0] W_MAX = 16'h7fff;
   localparam longint ACC_HI = 64'sh7fff_ffff_ffff_ffff;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam longint OUT_HI = (64'sd1 <<< (OUT_BITS - 1)) - 1;
   localparam longint OUT_LO = -OUT_HI - 1;

   typedef struct {
      logic signed [15:0] nbr_sx;
      logic signed [15:0] nbr_sy;
      logic signed [15:0] nbr_sz;
      logic signed [15:0] exch_coef;
      logic               nbr_valid;
      logic signed [15:0] own_sx;
      logic signed [15:0] own_sy;
      logic signed [15:0] own_sz;
      logic signed [15:0] ratio_x;
      logic signed [15:0] ratio_y;
      logic signed [15:0] ratio_z;
      logic               last_item;
   } site_item_type;

   typedef struct {
      logic signed [OUT_BITS-1:0] energy;
      logic                       ovf;
   } site_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [SPIN_BITS_DEF-1:0]  req_nbr_sx = '0;
   logic signed [SPIN_BITS_DEF-1:0]  req_nbr_sy = '0;
   logic signed [SPIN_BITS_DEF-1:0]  req_nbr_sz = '0;
   logic signed [COEF_BITS-1:0]      req_exch_coef = '0;
   logic                             req_nbr_valid = 1'b0;
   logic signed [SPIN_BITS_DEF-1:0]  req_own_sx = '0;
   logic signed [SPIN_BITS_DEF-1:0]  req_own_sy = '0;
   logic signed [SPIN_BITS_DEF-1:0]  req_own_sz = '0;
   logic signed [COEF_BITS-1:0]      req_ratio_x = '0;
   logic signed [COEF_BITS-1:0]      req_ratio_y = '0;
   logic signed [COEF_BITS-1:0]      req_ratio_z = '0;
   logic                             req_last_item = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [OUT_BITS-1:0]       rsp_site_energy;
   logic                             rsp_energy_overflow;
   logic                             csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]          csr_index = '0;
   logic [CSR_DATA_BITS-1:0]         csr_wdata = '0;

   // Predictor state and register copies
   longint                   energy_sum = 0;
   bit                       sum_clipped = 1'b0;
   logic [MODE_BITS-1:0]     mode_reg = '0;
   logic signed [15:0]       coef_x = '0, coef_y = '0, coef_z = '0;
   logic signed [15:0]       field_x = '0, field_y = '0, field_z = '0;
   site_result_type          energy_q[$];

   int          fails = 0;
   int          idle_cycles = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int unsigned rsp_hold_req = 0;
   int unsigned stall_left = 0;
   int unsigned go_left = 0;

   heisenberg_site_energy uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_nbr_sx          (req_nbr_sx),
      .req_nbr_sy          (req_nbr_sy),
      .req_nbr_sz          (req_nbr_sz),
      .req_exch_coef       (req_exch_coef),
      .req_nbr_valid       (req_nbr_valid),
      .req_own_sx          (req_own_sx),
      .req_own_sy          (req_own_sy),
      .req_own_sz          (req_own_sz),
      .req_ratio_x         (req_ratio_x),
      .req_ratio_y         (req_ratio_y),
      .req_ratio_z         (req_ratio_z),
      .req_last_item       (req_last_item),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_site_energy     (rsp_site_energy),
      .rsp_energy_overflow (rsp_energy_overflow),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Round half up: add half an output LSB, then floor shift
   function automatic longint round_shift(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   // Saturating add into the 64-bit energy sum
   function automatic void sum_in(input longint term);
      longint s;
      s = energy_sum + term;
      if (term > 0 && s < energy_sum) begin
         s = ACC_HI;
         sum_clipped = 1'b1;
      end else if (term < 0 && s > energy_sum) begin
         s = ACC_LO;
         sum_clipped = 1'b1;
      end
      energy_sum = s;
   endfunction

   // Fold one accepted item into the site sum; on the last item queue the energy
   function automatic void fold_item(input site_item_type it);
      longint sx, sy, sz, rx, ry, rz, cx, cy, cz, dot, e;
      site_result_type res;
      sx = it.own_sx;
      sy = it.own_sy;
      sz = it.own_sz;
      if (it.nbr_valid) begin
         dot = sx * longint'(it.nbr_sx) + sy * longint'(it.nbr_sy) + sz * longint'(it.nbr_sz);
         sum_in(round_shift(longint'(it.exch_coef) * dot, EXCH_RND));
      end
      if (!it.last_item)
         return;
      rx = it.ratio_x;
      ry = it.ratio_y;
      rz = it.ratio_z;
      cx = coef_x;
      cy = coef_y;
      cz = coef_z;
      if (mode_reg[MODE_RHOMB]) begin
         sum_in(round_shift(2 * cz * rz * (sz * sz), AXIS_RND));
         sum_in(round_shift(2 * cx * (sx * sx - sy * sy), EXCH_RND));
      end else begin
         if (mode_reg[MODE_AXIS_X])
            sum_in(round_shift(2 * cx * rx * (sx * sx), AXIS_RND));
         if (mode_reg[MODE_AXIS_Y])
            sum_in(round_shift(2 * cy * ry * (sy * sy), AXIS_RND));
         if (mode_reg[MODE_AXIS_Z])
            sum_in(round_shift(2 * cz * rz * (sz * sz), AXIS_RND));
      end
      if (mode_reg[MODE_FIELD])
         sum_in(-8 * (longint'(field_x) * sx + longint'(field_y) * sy + longint'(field_z) * sz));
      // clamp to the 48-bit output range
      e = energy_sum;
      res.ovf = sum_clipped;
      if (e > OUT_HI) begin
         e = OUT_HI;
         res.ovf = 1'b1;
      end else if (e < OUT_LO) begin
         e = OUT_LO;
         res.ovf = 1'b1;
      end
      res.energy = e[OUT_BITS-1:0];
      energy_q.push_back(res);
      energy_sum = 0;
      sum_clipped = 1'b0;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   // Field value biased toward the extremes
   function automatic logic [15:0] pick_word();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return W_MIN;
      if (r < 16)
         return W_MAX;
      if (r < 20)
         return 16'h0000;
      if (r < 24)
         return 16'hffff;
      return 16'($urandom);
   endfunction

   function automatic site_item_type uniform_item(input logic [15:0] w, input logic nv,
                                                  input logic last);
      site_item_type it;
      it.nbr_sx = w;
      it.nbr_sy = w;
      it.nbr_sz = w;
      it.exch_coef = w;
      it.nbr_valid = nv;
      it.own_sx = w;
      it.own_sy = w;
      it.own_sz = w;
      it.ratio_x = w;
      it.ratio_y = w;
      it.ratio_z = w;
      it.last_item = last;
      return it;
   endfunction

   function automatic site_item_type random_item();
      site_item_type it;
      it.nbr_sx = pick_word();
      it.nbr_sy = pick_word();
      it.nbr_sz = pick_word();
      it.exch_coef = pick_word();
      it.nbr_valid = ($urandom_range(0, 9) != 0);
      it.own_sx = pick_word();
      it.own_sy = pick_word();
      it.own_sz = pick_word();
      it.ratio_x = pick_word();
      it.ratio_y = pick_word();
      it.ratio_z = pick_word();
      it.last_item = 1'b0;
      return it;
   endfunction

   // Write all registers plus one unused index, then update the register copies
   task automatic load_regs(input logic [4:0] mode, input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az, input logic [15:0] bx, input logic [15:0] by,
                            input logic [15:0] bz);
      logic [CSR_IDX_BITS-1:0] idx_list[8];
      logic [15:0]             data_list[8];
      idx_list = '{CSR_MODE, CSR_COEF_X, CSR_COEF_Y, CSR_COEF_Z,
                   CSR_FIELD_X, CSR_FIELD_Y, CSR_FIELD_Z, CSR_UNUSED};
      data_list = '{{11'($urandom), mode}, ax, ay, az, bx, by, bz, 16'($urandom)};
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= data_list[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      mode_reg = mode;
      coef_x = ax;
      coef_y = ay;
      coef_z = az;
      field_x = bx;
      field_y = by;
      field_z = bz;
   endtask

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input site_item_type it);
      int unsigned gap;
      gap = req_quiet ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_nbr_sx <= it.nbr_sx;
      req_nbr_sy <= it.nbr_sy;
      req_nbr_sz <= it.nbr_sz;
      req_exch_coef <= it.exch_coef;
      req_nbr_valid <= it.nbr_valid;
      req_own_sx <= it.own_sx;
      req_own_sy <= it.own_sy;
      req_own_sz <= it.own_sz;
      req_ratio_x <= it.ratio_x;
      req_ratio_y <= it.ratio_y;
      req_ratio_z <= it.ratio_z;
      req_last_item <= it.last_item;
      do @(posedge clock); while (req_stall);
      fold_item(it);
   endtask

   // Drop valid and wait until every queued energy has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (energy_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One site of random length; own spin and ratios mostly held across the site
   task automatic send_random_site(output int unsigned len);
      site_item_type site_tpl, it;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         len = $urandom_range(1, 4);
      else if (r < 95)
         len = $urandom_range(5, 12);
      else
         len = $urandom_range(13, 40);
      site_tpl = random_item();
      for (int k = 0; k < len; k++) begin
         it = random_item();
         if ($urandom_range(0, 99) >= 15) begin
            it.own_sx = site_tpl.own_sx;
            it.own_sy = site_tpl.own_sy;
            it.own_sz = site_tpl.own_sz;
            it.ratio_x = site_tpl.ratio_x;
            it.ratio_y = site_tpl.ratio_y;
            it.ratio_z = site_tpl.ratio_z;
         end
         it.last_item = (k == len - 1);
         send_item(it);
      end
   endtask

   task automatic test_directed();
      site_item_type it;
      logic [4:0] one_bit[4];
      one_bit = '{5'b00001, 5'b00010, 5'b00100, 5'b01000};
      // reset configuration: exchange only
      it = uniform_item(W_MAX, 1'b1, 1'b1);
      send_item(it);
      wait_drained();
      load_regs(5'b01111, W_MIN, W_MAX, 16'hffff, W_MAX, W_MIN, 16'h0001);
      // site with no neighbors gives only single-site terms
      it = uniform_item(W_MIN, 1'b0, 1'b1);
      send_item(it);
      // neighbors at both extremes; last item changes the own spin
      it = uniform_item(W_MIN, 1'b1, 1'b0);
      send_item(it);
      it = uniform_item(W_MAX, 1'b1, 1'b0);
      send_item(it);
      it = uniform_item(W_MIN, 1'b1, 1'b1);
      it.own_sx = 16'h0000;
      it.own_sy = W_MAX;
      send_item(it);
      // an empty item ahead of a real neighbor
      it = uniform_item(W_MAX, 1'b0, 1'b0);
      send_item(it);
      it = uniform_item(16'h0001, 1'b1, 1'b1);
      it.nbr_sz = W_MIN;
      send_item(it);
      wait_drained();
      // rhombic form with axis enables also set
      load_regs(5'b10111, W_MAX, W_MIN, W_MIN, 16'h0000, 16'h0000, 16'h0000);
      it = uniform_item(W_MIN, 1'b1, 1'b1);
      send_item(it);
      it = uniform_item(W_MAX, 1'b0, 1'b1);
      it.own_sy = W_MIN;
      send_item(it);
      wait_drained();
      // rhombic plus field at the negative extreme
      load_regs(5'b11000, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
      it = uniform_item(W_MIN, 1'b1, 1'b1);
      send_item(it);
      it = uniform_item(W_MAX, 1'b1, 1'b1);
      send_item(it);
      wait_drained();
      // each axis term and the field term alone
      for (int i = 0; i < 4; i++) begin
         load_regs(one_bit[i], pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word());
         it = random_item();
         it.last_item = 1'b1;
         send_item(it);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      int unsigned n, total;
      load_regs(5'b01111, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                pick_word());
      // receiver holds off while the sender keeps offering
      rsp_hold_req = LONG_HOLD;
      total = 0;
      while (total < 40) begin
         send_random_site(n);
         total += n;
      end
      wait_drained();
      // sender pauses until every site has come back
      repeat (3) begin
         send_random_site(n);
         wait_drained();
      end
   endtask

   task automatic test_random_phases();
      int unsigned n, sent;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: load_regs(5'b11111, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
            1: load_regs(5'b01111, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
            2: load_regs(5'b10000, pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word(), pick_word());
            default: load_regs(5'($urandom), pick_word(), pick_word(), pick_word(),
                               pick_word(), pick_word(), pick_word());
         endcase
         req_quiet = (p == 3);
         rsp_quiet = (p == 3 || p == 5);
         sent = 0;
         while (sent < 150) begin
            send_random_site(n);
            sent += n;
            if ($urandom_range(0, 49) == 0)
               wait_drained();
         end
         wait_drained();
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   // Long sites of extreme neighbors drive the energy far in both directions
   task automatic test_long_sites();
      site_item_type it;
      int unsigned n;
      load_regs(5'b00111, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX);
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      for (int dir = 0; dir < 2; dir++) begin
         it = uniform_item(W_MIN, 1'b1, 1'b0);
         if (dir == 1) begin
            it.nbr_sx = W_MAX;
            it.nbr_sy = W_MAX;
            it.nbr_sz = W_MAX;
         end
         for (int k = 0; k < LONG_COUNT; k++) begin
            it.last_item = (k == LONG_COUNT - 1);
            send_item(it);
         end
         // next site must start from a cleared sum
         send_random_site(n);
      end
      wait_drained();
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   // Receiver stall: random stretches, a forced long hold on request
   always @(posedge clock) begin
      if (rsp_hold_req != 0) begin
         stall_left = rsp_hold_req;
         rsp_hold_req = 0;
         go_left = 0;
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (go_left != 0 || rsp_quiet) begin
         rsp_stall <= 1'b0;
         if (go_left != 0)
            go_left--;
      end else begin
         rsp_stall <= 1'b0;
         go_left = $urandom_range(0, 12);
         stall_left = idle_len();
      end
   end

   // Compare each accepted result with the oldest queued energy
   always @(posedge clock) begin
      site_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (energy_q.size() == 0) begin
            $error("unexpected result: site_energy %0d, energy_overflow %0b",
                   rsp_site_energy, rsp_energy_overflow);
            fails++;
         end else begin
            exp_res = energy_q.pop_front();
            if (rsp_site_energy !== exp_res.energy) begin
               $error("site_energy: expected %0d, actual %0d", exp_res.energy, rsp_site_energy);
               fails++;
            end
            if (rsp_energy_overflow !== exp_res.ovf) begin
               $error("energy_overflow: expected %0b, actual %0b", exp_res.ovf,
                      rsp_energy_overflow);
               fails++;
            end
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_phases();
      test_long_sites();
      wait_drained();
      if (fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
